// ===== rtl/pws_pkg.sv =====
// Shared definitions for the plane-wave surface sampler: widths, codes,
// the pipeline enable bundle and the quarter-wave sine table.
// No dependencies; every other file of the block imports this package.
package pws_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;
  localparam int QUARTER         = SINE_N / 4;
  localparam int DEPTH_LEVELS    = 16;
  localparam int DEPTH_W         = $clog2(DEPTH_LEVELS);

  localparam int COORD_W = 8;
  localparam int PHASE_W = 32;
  localparam int AMP_W   = 23;
  localparam int GAIN_W  = 17;
  localparam int RES_W   = 24;
  localparam int MAG_W   = 17;
  localparam int TRIG_W  = MAG_W + 1;

  localparam logic [63:0] PI2_Q30 = 64'd6746518852;

  typedef enum logic {
    ACT_EVAL = 1'b0,
    ACT_LOAD = 1'b1
  } pws_action_t;

  typedef enum logic [2:0] {
    REG_STEP_X   = 3'd0,
    REG_STEP_Y   = 3'd1,
    REG_ORIGIN   = 3'd2,
    REG_AMPL     = 3'd3,
    REG_SLOPE_X  = 3'd4,
    REG_SLOPE_Y  = 3'd5
  } pws_reg_t;

  // One load enable per pipeline stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pws_en_t;

  typedef logic [MAG_W-1:0] quarter_tab_t [0:QUARTER];

  // First quadrant of the sine, round(65536*sin), from a Q30 Taylor series.
  // Evaluated at elaboration only.
  function automatic quarter_tab_t build_quarter();
    quarter_tab_t tab;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    longint       sum;
    int           i;
    for (i = 0; i <= QUARTER; i++) begin
      x    = (64'(i) * PI2_Q30 + 64'(SINE_N / 2)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      sum  = longint'(x);
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      tab[i] = MAG_W'((sum + 8192) >>> 14);
    end
    tab[0] = '0;
    return tab;
  endfunction

  localparam quarter_tab_t SINE_QUARTER = build_quarter();

endpackage

// ===== rtl/pws_phase.sv =====
// Phase stages of the plane-wave surface sampler: column and row products,
// then the phase sum rounded to a sine table index. Depends on pws_pkg.
module pws_phase (
  input  logic                                 clk,
  input  pws_pkg::pws_en_t                     en,
  input  logic [pws_pkg::COORD_W-1:0]          col_i,
  input  logic [pws_pkg::COORD_W-1:0]          row_i,
  input  logic [pws_pkg::PHASE_W-1:0]          step_x_i,
  input  logic [pws_pkg::PHASE_W-1:0]          step_y_i,
  input  logic [pws_pkg::PHASE_W-1:0]          origin_i,
  output logic [pws_pkg::SINE_TABLE_BITS-1:0]  idx_o
);
  import pws_pkg::*;

  localparam logic [PHASE_W-1:0] HALF_STEP = PHASE_W'(1) << (PHASE_W - 1 - SINE_TABLE_BITS);

  logic [PHASE_W+COORD_W-1:0] px_full;
  logic [PHASE_W+COORD_W-1:0] py_full;
  logic [PHASE_W-1:0]         prod_x_nxt, prod_x_r;
  logic [PHASE_W-1:0]         prod_y_nxt, prod_y_r;
  logic [PHASE_W-1:0]         phase_sum;
  logic [SINE_TABLE_BITS-1:0] idx_nxt, idx_r;

  // Only the low word of each product matters: the phase wraps per turn.
  assign px_full    = col_i * step_x_i;
  assign py_full    = row_i * step_y_i;
  assign prod_x_nxt = px_full[PHASE_W-1:0];
  assign prod_y_nxt = py_full[PHASE_W-1:0];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
    end
  end

  // Adding half a table step turns the truncation into round-to-nearest.
  assign phase_sum = origin_i + prod_x_r + prod_y_r + HALF_STEP;
  assign idx_nxt   = phase_sum[PHASE_W-1 -: SINE_TABLE_BITS];

  always_ff @(posedge clk) begin
    if (en.s2) begin
      idx_r <= idx_nxt;
    end
  end

  assign idx_o = idx_r;

endmodule

// ===== rtl/pws_sincos.sv =====
// Sine and cosine lookup stage of the plane-wave surface sampler, built on
// the quarter-wave table with quadrant folding. Depends on pws_pkg.
module pws_sincos (
  input  logic                                 clk,
  input  pws_pkg::pws_en_t                     en,
  input  logic [pws_pkg::SINE_TABLE_BITS-1:0]  idx_i,
  output logic signed [pws_pkg::TRIG_W-1:0]    sa_o,
  output logic signed [pws_pkg::TRIG_W-1:0]    ca_o
);
  import pws_pkg::*;

  localparam int J_W = SINE_TABLE_BITS - 2;

  logic [1:0]                quad;
  logic [J_W-1:0]            j;
  logic [J_W:0]              j_rev;
  logic signed [TRIG_W-1:0]  pos_j;
  logic signed [TRIG_W-1:0]  pos_r;
  logic signed [TRIG_W-1:0]  sa_nxt, sa_r;
  logic signed [TRIG_W-1:0]  ca_nxt, ca_r;

  assign quad  = idx_i[SINE_TABLE_BITS-1 -: 2];
  assign j     = idx_i[J_W-1:0];
  assign j_rev = (J_W+1)'(QUARTER) - {1'b0, j};
  assign pos_j = signed'({1'b0, SINE_QUARTER[{1'b0, j}]});
  assign pos_r = signed'({1'b0, SINE_QUARTER[j_rev]});

  // The cosine is the sine one quadrant further on.
  always_comb begin
    case (quad)
      2'd0: begin
        sa_nxt = pos_j;
        ca_nxt = pos_r;
      end
      2'd1: begin
        sa_nxt = pos_r;
        ca_nxt = -pos_j;
      end
      2'd2: begin
        sa_nxt = -pos_j;
        ca_nxt = -pos_r;
      end
      default: begin
        sa_nxt = -pos_r;
        ca_nxt = pos_j;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      sa_r <= sa_nxt;
      ca_r <= ca_nxt;
    end
  end

  assign sa_o = sa_r;
  assign ca_o = ca_r;

endmodule

// ===== rtl/pws_scale.sv =====
// Scaling stages of the plane-wave surface sampler: amplitude products, then
// slope and pressure products, each rounded and saturated. Depends on pws_pkg.
module pws_scale (
  input  logic                               clk,
  input  pws_pkg::pws_en_t                   en,
  input  logic [pws_pkg::AMP_W-1:0]          amp_i,
  input  logic signed [pws_pkg::RES_W-1:0]   slope_x_i,
  input  logic signed [pws_pkg::RES_W-1:0]   slope_y_i,
  input  logic [pws_pkg::GAIN_W-1:0]         gain_i,
  input  logic signed [pws_pkg::TRIG_W-1:0]  sa_i,
  input  logic signed [pws_pkg::TRIG_W-1:0]  ca_i,
  output logic signed [pws_pkg::RES_W-1:0]   elev_o,
  output logic signed [pws_pkg::RES_W-1:0]   sx_o,
  output logic signed [pws_pkg::RES_W-1:0]   sy_o,
  output logic signed [pws_pkg::RES_W-1:0]   pres_o
);
  import pws_pkg::*;

  localparam int AMP_PROD_W   = AMP_W + 1 + TRIG_W;
  localparam int SLOPE_PROD_W = 2 * RES_W;
  localparam int GAIN_PROD_W  = GAIN_W + 1 + RES_W;
  localparam int WIDE_W       = SLOPE_PROD_W + 1;

  localparam logic signed [WIDE_W-1:0] SAT_HI  = (WIDE_W'(1) <<< (RES_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] SAT_LO  = -(WIDE_W'(1) <<< (RES_W - 1));
  localparam logic signed [WIDE_W-1:0] RND_ADD = WIDE_W'(1) <<< 15;

  // Drop 16 fraction bits rounding half up, then clamp to the result range.
  function automatic logic signed [RES_W-1:0] rnd_sat(input logic signed [WIDE_W-1:0] p);
    logic signed [WIDE_W-1:0] q;
    q = (p + RND_ADD) >>> 16;
    if (q > SAT_HI) begin
      return RES_W'(SAT_HI);
    end
    if (q < SAT_LO) begin
      return RES_W'(SAT_LO);
    end
    return RES_W'(q);
  endfunction

  logic signed [AMP_PROD_W-1:0]   prod_ec;
  logic signed [AMP_PROD_W-1:0]   prod_es;
  logic signed [RES_W-1:0]        elev_nxt, elev_r;
  logic signed [RES_W-1:0]        as_nxt, as_r;
  logic signed [SLOPE_PROD_W-1:0] prod_sx;
  logic signed [SLOPE_PROD_W-1:0] prod_sy;
  logic signed [GAIN_PROD_W-1:0]  prod_g;
  logic signed [RES_W-1:0]        sx_nxt, sx_r;
  logic signed [RES_W-1:0]        sy_nxt, sy_r;
  logic signed [RES_W-1:0]        pres_nxt, pres_r;

  assign prod_ec  = signed'({1'b0, amp_i}) * ca_i;
  assign prod_es  = signed'({1'b0, amp_i}) * sa_i;
  assign elev_nxt = rnd_sat(WIDE_W'(prod_ec));
  assign as_nxt   = rnd_sat(WIDE_W'(prod_es));

  always_ff @(posedge clk) begin
    if (en.s4) begin
      elev_r <= elev_nxt;
      as_r   <= as_nxt;
    end
  end

  // The slope negation is done on the wide product, so the most negative
  // coefficient times the most negative amplitude cannot wrap.
  assign prod_sx  = slope_x_i * as_r;
  assign prod_sy  = slope_y_i * as_r;
  assign prod_g   = signed'({1'b0, gain_i}) * elev_r;
  assign sx_nxt   = rnd_sat(-WIDE_W'(prod_sx));
  assign sy_nxt   = rnd_sat(-WIDE_W'(prod_sy));
  assign pres_nxt = rnd_sat(WIDE_W'(prod_g));

  always_ff @(posedge clk) begin
    if (en.s5) begin
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      pres_r <= pres_nxt;
    end
  end

  logic signed [RES_W-1:0] elev_out_r;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      elev_out_r <= elev_r;
    end
  end

  assign elev_o = elev_out_r;
  assign sx_o   = sx_r;
  assign sy_o   = sy_r;
  assign pres_o = pres_r;

endmodule

// ===== rtl/plane_wave_surface_sampler.sv =====
// Top level of the plane-wave surface sampler: configuration registers,
// depth gain table, stage valids and handshakes.
// Depends on pws_pkg, pws_phase, pws_sincos and pws_scale.
//
// Usage. Software writes the six wave registers over the cfg_ channel
// (index 0 step_phase_x through 5 slope_y; other indexes are ignored) and
// loads the depth gain entries with load transactions on the in_ channel
// (in_tuser high). Software must change configuration only while the block
// is idle; the block does not enforce this. cfg_ready is always high. Each
// evaluate transaction (in_tuser low) names a grid cell and a depth level and
// yields one result transaction on the out_ channel; a load yields none. The
// 8-bit column and row indexes span the whole 256 by 256 grid, and the 4-bit
// depth index spans all 16 entries. One cell is accepted every cycle while
// out_tready is high, and each passes through five register stages (products,
// phase sum, sine lookup, amplitude products, slope and pressure products)
// to out_tvalid. When the receiver stalls, each stage holds while the one
// after it is full, so bubbles are squeezed out and in_tready falls only when
// all five stages hold results. Reset clears the valids and loads the register
// reset values; the gain table is not cleared and must be loaded before use.
module plane_wave_surface_sampler (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0 up: col_index[7:0], row_index[15:8], depth_index[19:16],
  // gain_value[36:20], zero fill[39:37].
  input  logic [39:0] in_tdata,
  // tuser from bit 0 up: action[0].
  input  logic [0:0]  in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0 up: elevation[23:0], slope_along_x[47:24],
  // slope_along_y[71:48], pressure[95:72].
  output logic [95:0] out_tdata,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pws_pkg::*;

  localparam int STAGES = 5;

  // Configuration registers.
  logic [PHASE_W-1:0]      step_x_r;
  logic [PHASE_W-1:0]      step_y_r;
  logic [PHASE_W-1:0]      origin_r;
  logic [AMP_W-1:0]        amp_r;
  logic signed [RES_W-1:0] slope_x_r;
  logic signed [RES_W-1:0] slope_y_r;

  // Input fields.
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [DEPTH_W-1:0] depth;
  logic [GAIN_W-1:0]  gain_in;
  logic               is_load;

  assign col     = in_tdata[7:0];
  assign row     = in_tdata[15:8];
  assign depth   = in_tdata[19:16];
  assign gain_in = in_tdata[36:20];
  assign is_load = (in_tuser[0] == ACT_LOAD);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r  <= '0;
      step_y_r  <= '0;
      origin_r  <= '0;
      amp_r     <= AMP_W'(65536);
      slope_x_r <= '0;
      slope_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_X:  step_x_r  <= cfg_data;
        REG_STEP_Y:  step_y_r  <= cfg_data;
        REG_ORIGIN:  origin_r  <= cfg_data;
        REG_AMPL:    amp_r     <= cfg_data[AMP_W-1:0];
        REG_SLOPE_X: slope_x_r <= signed'(cfg_data[RES_W-1:0]);
        REG_SLOPE_Y: slope_y_r <= signed'(cfg_data[RES_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Stage valids and the ready chain. A stage may load whenever it is empty
  // or its content moves on in the same cycle.
  logic [STAGES-1:0] v_r, v_nxt;
  logic [STAGES-1:0] rdy;
  pws_en_t           en;

  always_comb begin
    rdy[STAGES-1] = ~v_r[STAGES-1] | out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = ~v_r[k] | rdy[k+1];
    end
  end

  assign en.s1 = rdy[0];
  assign en.s2 = rdy[1];
  assign en.s3 = rdy[2];
  assign en.s4 = rdy[3];
  assign en.s5 = rdy[4];

  assign in_tready = rdy[0];

  // Only evaluate transactions occupy the pipeline.
  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_tvalid & ~is_load;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign out_tvalid = v_r[STAGES-1];

  // Depth gain table. Loads write at acceptance and evaluates read at
  // acceptance, so a load is always seen by every later evaluate.
  logic [GAIN_W-1:0] gain_tab [DEPTH_LEVELS];
  logic [GAIN_W-1:0] g1_r, g2_r, g3_r, g4_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && is_load) begin
      gain_tab[depth] <= gain_in;
    end
  end

  // The gain travels alongside the cell until the pressure product.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      g1_r <= gain_tab[depth];
    end
    if (en.s2) begin
      g2_r <= g1_r;
    end
    if (en.s3) begin
      g3_r <= g2_r;
    end
    if (en.s4) begin
      g4_r <= g3_r;
    end
  end

  logic [SINE_TABLE_BITS-1:0] idx;
  logic signed [TRIG_W-1:0]   sa;
  logic signed [TRIG_W-1:0]   ca;
  logic signed [RES_W-1:0]    elev;
  logic signed [RES_W-1:0]    sx;
  logic signed [RES_W-1:0]    sy;
  logic signed [RES_W-1:0]    pres;

  pws_phase u_phase (
    .clk      (clk),
    .en       (en),
    .col_i    (col),
    .row_i    (row),
    .step_x_i (step_x_r),
    .step_y_i (step_y_r),
    .origin_i (origin_r),
    .idx_o    (idx)
  );

  pws_sincos u_sincos (
    .clk   (clk),
    .en    (en),
    .idx_i (idx),
    .sa_o  (sa),
    .ca_o  (ca)
  );

  pws_scale u_scale (
    .clk       (clk),
    .en        (en),
    .amp_i     (amp_r),
    .slope_x_i (slope_x_r),
    .slope_y_i (slope_y_r),
    .gain_i    (g4_r),
    .sa_i      (sa),
    .ca_i      (ca),
    .elev_o    (elev),
    .sx_o      (sx),
    .sy_o      (sy),
    .pres_o    (pres)
  );

  assign out_tdata = {pres, sy, sx, elev};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for plane_wave_surface_sampler: a queued stream driver,
// a result monitor and a bit-exact predictor of the sampled surface.
// Depends on pws_pkg for the action and register codes and on the block's RTL.
module tb;
  import pws_pkg::*;

  // Sine lookup geometry and fixed-point constants of the predictor.
  localparam int          LUT_BITS     = 10;
  localparam int          LUT_SIZE     = 1 << LUT_BITS;
  localparam int          LUT_QUARTER  = LUT_SIZE / 4;
  localparam logic [63:0] TWO_PI_Q30   = 64'd6746518852;
  localparam logic [31:0] PHASE_ROUND  = 32'd1 << (31 - LUT_BITS);
  localparam longint      Q716_MAX     = 64'sd8388607;
  localparam longint      Q716_MIN     = -64'sd8388608;

  // Register indexes the block does not decode; writes to them must change nothing.
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;

  // Five pipeline stages; the pause before a register write leaves some margin.
  localparam int          DRAIN_MARGIN = 8;
  localparam int          END_MARGIN   = 20;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_ITEMS  = 205;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CFG,
    OP_DRAIN,
    OP_MODE
  } stim_kind_t;

  // One entry of the stimulus script.
  typedef struct {
    stim_kind_t  kind;
    pws_action_t action;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [3:0]  depth;
    logic [16:0] gain;
    logic [2:0]  reg_index;
    logic [31:0] reg_value;
    int          arg;  // idle cycles before an item or after a drain, stall percent for a mode
  } stim_op_t;

  // Layout of out_tdata, elevation in the lowest bits.
  typedef struct packed {
    logic signed [23:0] pressure;
    logic signed [23:0] slope_y;
    logic signed [23:0] slope_x;
    logic signed [23:0] elevation;
  } surface_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  plane_wave_surface_sampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: a copy of the wave registers with their reset values and of the
  // depth gain table.
  logic [31:0]        wave_step_x = '0;
  logic [31:0]        wave_step_y = '0;
  logic [31:0]        wave_origin = '0;
  logic [22:0]        wave_amp    = 23'd65536;
  logic signed [23:0] wave_kx     = '0;
  logic signed [23:0] wave_ky     = '0;
  logic [16:0]        gain_mem [0:15];
  int                 sine_lut [0:LUT_SIZE-1];

  stim_op_t pending_ops [$];
  surface_t pending_surface [$];
  stim_op_t cur_op;
  bit       op_live = 1'b0;
  int       op_wait = 0;
  logic [15:0] gain_loaded = '0;  // entries the script has loaded so far
  int       cells_sent = 0;       // evaluate transactions accepted
  int       cells_returned = 0;   // result transactions accepted
  int       rx_stall_pct = 0;
  int       rx_hold = 0;
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       stim_done = 1'b0;

  // Full-turn sine in Q1.16: a Q30 Taylor series over the first quadrant, rounded to
  // 16 fractional bits, then mirrored into the other three quadrants.
  function automatic void build_sine_lut();
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    longint      acc;
    int          v;
    int          i;
    int          n;
    for (i = 0; i <= LUT_QUARTER; i++) begin
      ang  = (64'(i) * TWO_PI_Q30 + 64'(LUT_SIZE / 2)) >> LUT_BITS;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = longint'(ang);
      for (n = 1; n <= 7; n++) begin
        term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = int'((acc + 8192) >>> 14);
      sine_lut[i] = v;
      sine_lut[(LUT_SIZE / 2 - i) % LUT_SIZE] = v;
      if (i != 0) begin
        sine_lut[LUT_SIZE / 2 + i] = -v;
        sine_lut[(LUT_SIZE - i) % LUT_SIZE] = -v;
      end
    end
    sine_lut[0] = 0;
    sine_lut[LUT_SIZE / 2] = 0;
  endfunction

  // Drop 16 fractional bits, rounding halves toward plus infinity.
  function automatic longint rescale_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clip_q716(longint v);
    if (v > Q716_MAX) begin
      return Q716_MAX;
    end
    if (v < Q716_MIN) begin
      return Q716_MIN;
    end
    return v;
  endfunction

  // Surface values of one grid cell under the current wave registers and gain table.
  function automatic surface_t surface_at_cell(logic [7:0] col, logic [7:0] row,
                                               logic [3:0] depth);
    logic [31:0]        phase;
    logic [LUT_BITS-1:0] sin_idx;
    logic [LUT_BITS-1:0] cos_idx;
    longint             elev;
    longint             amp_sin;
    surface_t           s;
    phase   = wave_origin + 32'(col) * wave_step_x + 32'(row) * wave_step_y + PHASE_ROUND;
    sin_idx = phase[31 -: LUT_BITS];
    cos_idx = sin_idx + LUT_BITS'(LUT_QUARTER);
    elev    = clip_q716(rescale_q16(longint'(wave_amp) * sine_lut[cos_idx]));
    amp_sin = clip_q716(rescale_q16(longint'(wave_amp) * sine_lut[sin_idx]));
    s.elevation = 24'(elev);
    s.slope_x   = 24'(clip_q716(rescale_q16(-(longint'(wave_kx) * amp_sin))));
    s.slope_y   = 24'(clip_q716(rescale_q16(-(longint'(wave_ky) * amp_sin))));
    s.pressure  = 24'(clip_q716(rescale_q16(longint'(gain_mem[depth]) * elev)));
    return s;
  endfunction

  function automatic void apply_setting(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_STEP_X:  wave_step_x = val;
      REG_STEP_Y:  wave_step_y = val;
      REG_ORIGIN:  wave_origin = val;
      REG_AMPL:    wave_amp    = val[22:0];
      REG_SLOPE_X: wave_kx     = val[23:0];
      REG_SLOPE_Y: wave_ky     = val[23:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [23:0] want,
                                      logic signed [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Grid coordinate with the edges of the grid well represented.
  function automatic logic [7:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      return 8'd0;
    end
    if (r < 20) begin
      return 8'd255;
    end
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // Script building. The initial block below fills pending_ops through these.
  // ---------------------------------------------------------------------------
  task automatic queue_item(pws_action_t act, logic [7:0] col, logic [7:0] row,
                            logic [3:0] depth, logic [16:0] gain, int gap);
    stim_op_t op;
    op.kind   = OP_ITEM;
    op.action = act;
    op.col    = col;
    op.row    = row;
    op.depth  = depth;
    op.gain   = gain;
    op.arg    = gap;
    if (act == ACT_LOAD) begin
      gain_loaded[depth] = 1'b1;
    end
    pending_ops.push_back(op);
  endtask

  task automatic queue_write(logic [2:0] idx, logic [31:0] val);
    stim_op_t op;
    op.kind      = OP_CFG;
    op.reg_index = idx;
    op.reg_value = val;
    op.arg       = 0;
    pending_ops.push_back(op);
  endtask

  // Hold the sender until every evaluate transaction has produced its result, then
  // let the given number of further cycles pass.
  task automatic queue_drain(int margin);
    stim_op_t op;
    op.kind = OP_DRAIN;
    op.arg  = margin;
    pending_ops.push_back(op);
  endtask

  task automatic queue_mode(int pct);
    stim_op_t op;
    op.kind = OP_MODE;
    op.arg  = pct;
    pending_ops.push_back(op);
  endtask

  // Registers are only rewritten once the pipeline has emptied.
  task automatic queue_settings(logic [31:0] sx, logic [31:0] sy, logic [31:0] org,
                                logic [22:0] amp, logic [23:0] kx, logic [23:0] ky);
    queue_drain(DRAIN_MARGIN);
    queue_write(REG_STEP_X, sx);
    queue_write(REG_STEP_Y, sy);
    queue_write(REG_ORIGIN, org);
    queue_write(REG_AMPL, {9'd0, amp});
    queue_write(REG_SLOPE_X, {{8{kx[23]}}, kx});
    queue_write(REG_SLOPE_Y, {{8{ky[23]}}, ky});
  endtask

  // ---------------------------------------------------------------------------
  // Driver. It walks pending_ops one entry at a time. An accepted evaluate
  // transaction is run through the predictor at the edge where it is taken, so
  // the gain table and the registers it sees are those in force at that moment.
  // The next valid values are worked out in blocking variables first, so each
  // valid gets a single nonblocking assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_inputs
    logic nx_in_valid;
    logic nx_cfg_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      op_live = 1'b0;
    end else begin
      nx_in_valid  = in_tvalid;
      nx_cfg_valid = cfg_valid;
      if (in_tvalid && in_tready) begin
        if (cur_op.action == ACT_LOAD) begin
          gain_mem[cur_op.depth] = cur_op.gain;
        end else begin
          pending_surface.push_back(surface_at_cell(cur_op.col, cur_op.row, cur_op.depth));
          cells_sent++;
        end
        nx_in_valid = 1'b0;
        op_live     = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_setting(cur_op.reg_index, cur_op.reg_value);
        nx_cfg_valid = 1'b0;
        op_live      = 1'b0;
      end
      if (!op_live && pending_ops.size() != 0) begin
        cur_op  = pending_ops.pop_front();
        op_live = 1'b1;
        op_wait = cur_op.arg;
      end
      if (op_live && !nx_in_valid && !nx_cfg_valid) begin
        case (cur_op.kind)
          OP_ITEM: begin
            if (op_wait > 0) begin
              op_wait--;
            end else begin
              nx_in_valid = 1'b1;
              in_tdata <= {3'b000, cur_op.gain, cur_op.depth, cur_op.row, cur_op.col};
              in_tuser <= cur_op.action;
            end
          end
          OP_CFG: begin
            nx_cfg_valid = 1'b1;
            cfg_index <= cur_op.reg_index;
            cfg_data  <= cur_op.reg_value;
          end
          OP_DRAIN: begin
            // The returned count is the monitor's value from before this edge, so the
            // wait can only come out long, never short.
            if (cells_sent == cells_returned) begin
              if (op_wait > 0) begin
                op_wait--;
              end else begin
                op_live = 1'b0;
              end
            end
          end
          OP_MODE: begin
            rx_stall_pct <= cur_op.arg;
            op_live = 1'b0;
          end
          default: op_live = 1'b0;
        endcase
      end
      in_tvalid <= nx_in_valid;
      cfg_valid <= nx_cfg_valid;
      stim_done <= !op_live && pending_ops.size() == 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every result transaction is checked against the oldest prediction.
  // out_tready drops in bursts of random length at the rate the script sets.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    surface_t got;
    surface_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        cells_returned <= cells_returned + 1;
        if (pending_surface.size() == 0) begin
          $error("result transaction with no evaluate transaction outstanding");
          fail_count++;
        end else begin
          want = pending_surface.pop_front();
          check_field("elevation", want.elevation, got.elevation);
          check_field("slope_along_x", want.slope_x, got.slope_x);
          check_field("slope_along_y", want.slope_y, got.slope_y);
          check_field("pressure", want.pressure, got.pressure);
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        rx_hold = $urandom_range(16, 0);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a lost result leaves the driver waiting forever, so this ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Script and end of run.
  // ---------------------------------------------------------------------------
  initial begin : run_script
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] org;
    logic [22:0] amp;
    logic [23:0] kx;
    logic [23:0] ky;
    logic [3:0]  d;
    logic [16:0] g;
    int          p;
    int          k;
    int          pct;
    int          gap;
    int          r;

    build_sine_lut();

    // Directed part. Loads come first so that no evaluate reads an empty entry;
    // the top entry holds the largest gain, well above one.
    queue_mode(0);
    queue_item(ACT_LOAD, 8'd0, 8'd0, 4'd0, 17'd0, 0);
    queue_item(ACT_LOAD, 8'd255, 8'd255, 4'd15, 17'd131071, 0);
    queue_item(ACT_LOAD, 8'd0, 8'd0, 4'd1, 17'd65536, 0);
    queue_item(ACT_LOAD, 8'd0, 8'd0, 4'd2, 17'd1, 0);
    // Reset registers: zero phase, unit amplitude, flat slopes.
    queue_item(ACT_EVAL, 8'd0, 8'd0, 4'd0, 17'd0, 0);
    queue_item(ACT_EVAL, 8'd0, 8'd0, 4'd15, 17'd131071, 0);
    queue_item(ACT_EVAL, 8'd0, 8'd0, 4'd1, 17'd0, 0);
    // Largest amplitude and wave numbers of both signs: the products saturate.
    queue_settings(32'h0040_0000, 32'h0100_0000, 32'h0, 23'h7F_FFFF, 24'h80_0000,
                   24'h7F_FFFF);
    queue_item(ACT_EVAL, 8'd0, 8'd0, 4'd15, 17'd0, 0);
    queue_item(ACT_EVAL, 8'd255, 8'd0, 4'd15, 17'd0, 0);
    queue_item(ACT_EVAL, 8'd0, 8'd255, 4'd1, 17'd0, 0);
    queue_item(ACT_EVAL, 8'd255, 8'd255, 4'd2, 17'd0, 0);
    queue_item(ACT_EVAL, 8'd64, 8'd32, 4'd0, 17'd0, 0);
    // Writes to undecoded indexes must leave the wave untouched.
    queue_drain(DRAIN_MARGIN);
    queue_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    queue_write(REG_SPARE_HI, 32'hFFFF_FFFF);
    queue_item(ACT_EVAL, 8'd1, 8'd1, 4'd15, 17'd0, 0);
    // Overwrite a gain entry and read it straight back.
    queue_item(ACT_LOAD, 8'd0, 8'd0, 4'd15, 17'h0_FFFF, 0);
    queue_item(ACT_EVAL, 8'd3, 8'd5, 4'd15, 17'd0, 0);
    // Half-turn origin, a step of minus one unit and a row step of exactly half a
    // table step, which sits on the rounding boundary of the lookup.
    queue_settings(32'hFFFF_FFFF, 32'h0020_0000, 32'h8000_0000, 23'd65536, 24'd65536,
                   -24'sd65536);
    queue_item(ACT_EVAL, 8'd0, 8'd0, 4'd0, 17'd0, 0);
    queue_item(ACT_EVAL, 8'd1, 8'd0, 4'd1, 17'd0, 0);
    queue_item(ACT_EVAL, 8'd0, 8'd1, 4'd1, 17'd0, 0);
    queue_item(ACT_EVAL, 8'd0, 8'd3, 4'd2, 17'd0, 0);
    queue_item(ACT_EVAL, 8'd128, 8'd128, 4'd15, 17'd0, 0);

    // Random part: one register setting per phase, the first two at the extremes.
    // Idle rates change between phases, one middle phase and the last run without
    // any idling.
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          sx = '0; sy = '0; org = '0; amp = '0; kx = '0; ky = '0;
        end
        1: begin
          sx = '1; sy = '1; org = '1; amp = '1; kx = 24'h7F_FFFF; ky = 24'h80_0000;
        end
        default: begin
          sx  = $urandom;
          sy  = $urandom >> $urandom_range(24, 0);
          org = $urandom;
          amp = 23'($urandom_range(23'h7F_FFFF) >> $urandom_range(8, 0));
          kx  = 24'($urandom);
          ky  = 24'($urandom >> $urandom_range(12, 8));
        end
      endcase
      case (p)
        0, 5:    pct = 5;
        1, 4:    pct = 15;
        2, 6:    pct = 35;
        default: pct = 0;
      endcase
      queue_settings(sx, sy, org, amp, kx, ky);
      queue_write((p % 2 == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      queue_mode(pct);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Partway through some phases the sender waits for the pipeline to empty.
        if (k == PHASE_ITEMS / 2 && (p == 2 || p == 5)) begin
          queue_drain(0);
        end
        gap = ($urandom_range(99) < pct) ? $urandom_range(17, 1) : 0;
        if ($urandom_range(99) < 15) begin
          r = $urandom_range(99);
          if (r < 20) begin
            g = 17'h1_FFFF;
          end else if (r < 30) begin
            g = '0;
          end else if (r < 50) begin
            g = 17'd65536;
          end else begin
            g = 17'($urandom);
          end
          queue_item(ACT_LOAD, 8'($urandom), 8'($urandom), 4'($urandom_range(15)), g, gap);
        end else begin
          do begin
            d = 4'($urandom_range(15));
          end while (!gain_loaded[d]);
          queue_item(ACT_EVAL, pick_coord(), pick_coord(), d, 17'($urandom), gap);
        end
      end
    end
    queue_drain(END_MARGIN);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
    end while (!stim_done);

    if (pending_surface.size() != 0) begin
      $error("%0d predicted results never came out", pending_surface.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pws_pkg.sv
rtl/pws_phase.sv
rtl/pws_sincos.sv
rtl/pws_scale.sv
rtl/plane_wave_surface_sampler.sv
dv/tb.sv
